[rtl/bdpc_pkg.sv]
// shared types, constants and helpers of the button debounce press classifier
package bdpc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int REG_IDX_W  = 2;

	localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST  = CFG_W'(20);
	localparam logic [CFG_W-1:0] SHORT_MAX_MS_RST = CFG_W'(2000);
	localparam logic [CFG_W-1:0] LONG_MIN_MS_RST  = CFG_W'(5000);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE_MS  = 2'd0,
		REG_SHORT_MAX_MS = 2'd1,
		REG_LONG_MIN_MS  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		EVT_NONE          = 2'd0,
		EVT_SHORT         = 2'd1,
		EVT_LONG_DETECTED = 2'd2,
		EVT_LONG_RELEASED = 2'd3
	} evt_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] short_max_ms;
		logic [CFG_W-1:0] long_min_ms;
	} cfg_t;

	typedef struct packed {
		logic                  previous_level;
		logic                  debounce_running;
		logic [TIMER_BITS-1:0] debounce_elapsed;
		logic                  press_pending;
		logic                  release_pending;
		logic                  long_seen;
		logic [TIMER_BITS-1:0] press_elapsed;
	} state_t;

	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		logic [TIMER_BITS-1:0] r;
		if (v == {TIMER_BITS{1'b1}}) begin
			r = v;
		end else begin
			r = TIMER_BITS'(v + 1'b1);
		end
		return r;
	endfunction

endpackage

[rtl/bdpc_cfg.sv]
// configuration register file of the press classifier
module bdpc_cfg import bdpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 cfg_ready,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= DEBOUNCE_MS_RST;
			cfg_q.short_max_ms <= SHORT_MAX_MS_RST;
			cfg_q.long_min_ms  <= LONG_MIN_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= cfg_data;
				REG_SHORT_MAX_MS: cfg_q.short_max_ms <= cfg_data;
				REG_LONG_MIN_MS:  cfg_q.long_min_ms  <= cfg_data;
				default: ; // unknown index, write dropped
			endcase
		end
	end

endmodule

[rtl/bdpc_core.sv]
// debounce and press classification state with its combinational next-state logic
module bdpc_core import bdpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic pin_level,
	input  cfg_t cfg,
	output evt_t evt
);

	state_t st_q;
	state_t st_d;
	logic   start;
	logic   fire;

	always_comb begin
		st_d = st_q;
		evt  = EVT_NONE;

		// timers advance first
		if (st_q.debounce_running) begin
			st_d.debounce_elapsed = sat_inc(st_q.debounce_elapsed);
		end
		st_d.press_elapsed = sat_inc(st_q.press_elapsed);

		start = (pin_level != st_q.previous_level) && !st_q.debounce_running;
		if (start) begin
			st_d.debounce_running = 1'b1;
			st_d.debounce_elapsed = '0;
		end
		st_d.previous_level = pin_level;

		fire = st_d.debounce_running &&
			(CMP_W'(st_d.debounce_elapsed) > CMP_W'(cfg.debounce_ms));
		if (fire) begin
			st_d.debounce_running = 1'b0;
			if (!pin_level) begin
				st_d.press_pending = 1'b1;
				st_d.press_elapsed = '0;
			end else begin
				st_d.release_pending = 1'b1;
			end
		end

		if (st_d.press_pending &&
			(CMP_W'(st_d.press_elapsed) > CMP_W'(cfg.long_min_ms))) begin
			st_d.long_seen       = 1'b1;
			st_d.press_pending   = 1'b0;
			st_d.release_pending = 1'b0;
			evt                  = EVT_LONG_DETECTED;
		end

		if (st_d.release_pending) begin
			// middle band clears without an event; above long band stays pending unless a long press was seen
			priority if (CMP_W'(st_d.press_elapsed) < CMP_W'(cfg.short_max_ms)) begin
				st_d.press_pending   = 1'b0;
				st_d.release_pending = 1'b0;
				evt                  = EVT_SHORT;
			end else if (CMP_W'(st_d.press_elapsed) <= CMP_W'(cfg.long_min_ms)) begin
				st_d.press_pending   = 1'b0;
				st_d.release_pending = 1'b0;
			end
			if (st_d.long_seen) begin
				st_d.long_seen       = 1'b0;
				st_d.release_pending = 1'b0;
				evt                  = EVT_LONG_RELEASED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.previous_level   <= 1'b1;
			st_q.debounce_running <= 1'b0;
			st_q.debounce_elapsed <= '0;
			st_q.press_pending    <= 1'b0;
			st_q.release_pending  <= 1'b0;
			st_q.long_seen        <= 1'b0;
			st_q.press_elapsed    <= '0;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

endmodule

[rtl/button_debounce_press_classifier_top.sv]
// Debounces one-millisecond samples of an active-low button pin and classifies each
// press as short, long detected or long released. Every accepted sample yields exactly
// one press_event (0 when nothing happened). One sample per clock: the whole update is
// counter increments and compares into the state registers, and the event lands in an
// output register, so it appears in the cycle after its sample is accepted; a new
// sample is taken every cycle unless that output register is full and stalled.
// Configuration writes are always ready; indexes above the last register are ignored.
module button_debounce_press_classifier_top import bdpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pin_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           press_event,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t       cfg;
	evt_t       evt;
	logic       accept;
	logic       out_valid_q;
	logic [1:0] press_event_q;

	// a new request can enter whenever the result slot is free or being drained
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	bdpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pin_level (pin_level),
		.cfg       (cfg),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			press_event_q <= evt;
		end
	end

	assign out_valid   = out_valid_q;
	assign press_event = press_event_q;

endmodule

[dv/tb_button_debounce_press_classifier_top.sv]
// self-checking testbench of the button debounce press classifier top level
`timescale 1ns / 100ps

module tb_button_debounce_press_classifier_top;
	import bdpc_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 pin_level;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           press_event;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// timing registers as the block should hold them
	logic [CFG_W-1:0] deb_ms   = DEBOUNCE_MS_RST;
	logic [CFG_W-1:0] short_ms = SHORT_MAX_MS_RST;
	logic [CFG_W-1:0] long_ms  = LONG_MIN_MS_RST;

	// debounce and press tracking of the predictor
	logic                  prev_level    = 1'b1;
	logic                  win_open      = 1'b0;
	logic [TIMER_BITS-1:0] win_count     = '0;
	logic                  press_armed   = 1'b0;
	logic                  release_armed = 1'b0;
	logic                  long_flag     = 1'b0;
	logic [TIMER_BITS-1:0] hold_count    = '0;

	logic sample_q[$];
	evt_t event_q[$];
	int   fail_count  = 0;
	int   dry_cycles  = 0;
	int   event_count = 0;
	int   send_gap    = 0;
	int   rx_hold     = 0;
	bit   no_idle     = 1'b0;

	button_debounce_press_classifier_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pin_level   (pin_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.press_event (press_event),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [TIMER_BITS-1:0] bump_sat(input logic [TIMER_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// advances the predicted state by one pin sample and returns its event
	function automatic evt_t classify_sample(input logic level);
		evt_t ev;
		ev = EVT_NONE;
		if (win_open) begin
			win_count = bump_sat(win_count);
		end
		hold_count = bump_sat(hold_count);
		if (level != prev_level && !win_open) begin
			win_open  = 1'b1;
			win_count = '0;
		end
		prev_level = level;
		if (win_open && win_count > deb_ms) begin
			win_open = 1'b0;
			if (!level) begin
				press_armed = 1'b1;
				hold_count  = '0;
			end else begin
				release_armed = 1'b1;
			end
		end
		if (press_armed && hold_count > long_ms) begin
			long_flag     = 1'b1;
			press_armed   = 1'b0;
			release_armed = 1'b0;
			ev            = EVT_LONG_DETECTED;
		end
		// a release in the long band with no long press stays armed
		if (release_armed) begin
			if (hold_count < short_ms) begin
				press_armed   = 1'b0;
				release_armed = 1'b0;
				ev            = EVT_SHORT;
			end else if (hold_count <= long_ms) begin
				press_armed   = 1'b0;
				release_armed = 1'b0;
			end
			if (long_flag) begin
				long_flag     = 1'b0;
				release_armed = 1'b0;
				ev            = EVT_LONG_RELEASED;
			end
		end
		return ev;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (no_idle) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		// keep the log short when things go badly wrong
		if (fail_count <= 50) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// sample request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				event_q.push_back(classify_sample(pin_level));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (sample_q.size() != 0) begin
					in_valid  <= 1'b1;
					pin_level <= sample_q.pop_front();
					send_gap  = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor with random back-pressure
	always @(posedge clk) begin
		evt_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (event_q.size() == 0) begin
					report_mismatch($sformatf("press_event %0d with nothing expected",
						press_event));
				end else begin
					want = event_q.pop_front();
					if (press_event !== want) begin
						report_mismatch($sformatf("event %0d: press_event %0d, expected %s",
							event_count, press_event, want.name()));
					end
				end
				event_count++;
			end
			if (rx_hold != 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else begin
				out_stall <= 1'b0;
				rx_hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			dry_cycles <= 0;
		end else begin
			dry_cycles <= dry_cycles + 1;
		end
	end

	initial begin
		do @(posedge clk); while (dry_cycles < WATCHDOG_LIMIT);
		$display("** button_debounce_press_classifier_top: FAILED **");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DEBOUNCE_MS:  deb_ms   = val;
			REG_SHORT_MAX_MS: short_ms = val;
			REG_LONG_MIN_MS:  long_ms  = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input int deb, input int shrt, input int lng);
		write_reg(REG_DEBOUNCE_MS, CFG_W'(deb));
		write_reg(REG_SHORT_MAX_MS, CFG_W'(shrt));
		write_reg(REG_LONG_MIN_MS, CFG_W'(lng));
		// unmapped index, must be ignored
		write_reg(REG_SPARE, CFG_W'($urandom));
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (sample_q.size() != 0 || in_valid || event_q.size() != 0);
	endtask

	task automatic push_run(input logic level, input int n);
		repeat (n) sample_q.push_back(level);
	endtask

	task automatic push_chatter(input int n);
		repeat (n) sample_q.push_back(1'($urandom_range(0, 1)));
	endtask

	// one press and release with bounce, a glitch, or plain noise
	task automatic push_gesture(output int n);
		int roll;
		int deb;
		int cap;
		int len[4];
		deb  = int'(deb_ms);
		cap  = int'(long_ms) + deb + 12;
		cap  = (cap > 150) ? 150 : cap;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			len[0] = $urandom_range(1, 12);
			push_chatter(len[0]);
			n = len[0];
		end else if (roll < 20) begin
			// low pulse too short to survive the window
			len[0] = $urandom_range(1, deb + 1);
			len[1] = $urandom_range(1, deb + 3);
			push_run(1'b0, len[0]);
			push_run(1'b1, len[1]);
			n = len[0] + len[1];
		end else begin
			len[0] = $urandom_range(0, deb / 2 + 1);
			len[1] = $urandom_range(0, cap);
			len[2] = $urandom_range(0, deb / 2 + 1);
			len[3] = $urandom_range(deb + 1, deb + 12);
			push_chatter(len[0]);
			push_run(1'b0, len[1]);
			push_chatter(len[2]);
			push_run(1'b1, len[3]);
			n = len[0] + len[1] + len[2] + len[3];
		end
	endtask

	task automatic run_phase(input int count);
		int queued;
		int n;
		bit drained;
		queued  = 0;
		drained = 1'b0;
		while (queued < count) begin
			push_gesture(n);
			queued += n;
			// let everything drain once mid-phase
			if (!drained && queued >= count / 2) begin
				wait_idle();
				drained = 1'b1;
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pin_level = 1'b1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE_MS;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: long press, short press, release with no press before it
		set_timing(1, 4, 8);
		push_run(1'b1, 2);
		push_run(1'b0, 12);
		push_run(1'b1, 4);
		push_run(1'b0, 3);
		push_run(1'b1, 3);
		push_run(1'b0, 1);
		push_run(1'b1, 4);
		wait_idle();

		set_timing(0, 0, 20);
		run_phase(300);
		set_timing($urandom_range(1, 6), 65535, 30);
		run_phase(300);
		no_idle = 1'b1;
		set_timing(3, 10, 0);
		run_phase(250);
		no_idle = 1'b0;
		repeat (3) begin
			set_timing($urandom_range(0, 5), $urandom_range(0, 40), $urandom_range(0, 60));
			run_phase(300);
		end

		// long hold with long press disabled, then a late release
		no_idle = 1'b1;
		set_timing(0, 10, 65535);
		push_run(1'b1, 5);
		push_run(1'b0, 60);
		wait_idle();
		set_timing(0, 10, 40);
		push_run(1'b0, 2);
		push_run(1'b1, 4);
		wait_idle();
		no_idle = 1'b0;

		// window that never closes, later edges are dropped
		set_timing(65535, 10, 40);
		push_chatter(60);
		push_run(1'b0, 20);
		push_run(1'b1, 20);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (event_q.size() != 0) begin
			report_mismatch($sformatf("%0d events never arrived", event_q.size()));
		end
		if (fail_count == 0) begin
			$display("** button_debounce_press_classifier_top: PASSED **");
		end else begin
			$display("** button_debounce_press_classifier_top: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/bdpc_pkg.sv
rtl/bdpc_cfg.sv
rtl/bdpc_core.sv
rtl/button_debounce_press_classifier_top.sv
dv/tb_button_debounce_press_classifier_top.sv
